>>> src/nuc2b_pkg.sv
// Package for the two-bit nucleotide unpacker.
// Holds the channel payload types, the character constants and the letter table.
// No dependencies; the core and the testbench refer to it by scoped names.
`default_nettype none

package nuc2b_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned LEN_W   = 8;

	localparam logic [CHAR_W-1:0] NEWLINE_CHAR      = 8'd10;
	localparam logic [LEN_W-1:0]  LINE_LENGTH_RESET = 8'd60;

	typedef struct packed {
		logic [WORD_W-1:0]  packed_word;
		logic [COUNT_W-1:0] symbol_count;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last_of_word;
	} result_t;

	typedef struct packed {
		logic [LEN_W-1:0] line_length;
	} cfg_t;

	// Codes 0 to 3 decode to a, t, g, c.
	function automatic logic [CHAR_W-1:0] letter_of_code(input logic [1:0] code);
		logic [CHAR_W-1:0] ch;
		case (code)
			2'd0: ch = 8'h61;
			2'd1: ch = 8'h74;
			2'd2: ch = 8'h67;
			2'd3: ch = 8'h63;
			default: ch = 8'h61;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

>>> src/nuc2b_stream_if.sv
// Valid/ready channel interface used for every port of the unpacker.
// The payload type is a parameter; the payload structs live in nuc2b_pkg.
`default_nettype none

interface nuc2b_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/nucleotide_two_bit_unpacker_core.sv
// Top level of the two-bit nucleotide unpacker: a digit-serial shift register
// and a small sequencer that emit one ASCII character per transfer.
// Depends on nuc2b_pkg and nuc2b_stream_if.
//
// Each accepted word is loaded into a shift register and its two-bit codes are
// shifted out from the top, one character per cycle, into an output register;
// a stalled result therefore holds the sequencer but the next word is taken as
// soon as the previous one has produced its last character. A full word is loaded
// and shifts out SYMBOLS_PER_WORD characters, plus a newline whenever the line
// counter wraps. A tail word with fewer symbols first shifts its unused pairs
// out, one pair a cycle, then any symbols it has; it ends with a newline and
// starts a fresh line. Line length is written through the cfg channel (values
// below SYMBOLS_PER_WORD act as SYMBOLS_PER_WORD) and must only be changed while
// the block is idle.
`default_nettype none

module nucleotide_two_bit_unpacker_core #(
	parameter int unsigned SYMBOLS_PER_WORD = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	nuc2b_stream_if.sink   item,
	nuc2b_stream_if.source result,
	nuc2b_stream_if.sink   cfg
);

	localparam int unsigned SR_W  = 2 * SYMBOLS_PER_WORD;
	localparam int unsigned CNT_W = $clog2(SYMBOLS_PER_WORD + 1);
	localparam int unsigned LEN_W = nuc2b_pkg::LEN_W;
	localparam int unsigned CW    = nuc2b_pkg::COUNT_W + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SKIP = 2'd1;
	localparam logic [1:0] ST_SYM  = 2'd2;
	localparam logic [1:0] ST_NL   = 2'd3;

	logic [1:0]                      state_q;
	logic [SR_W-1:0]                 sr_q;
	logic [CNT_W-1:0]                rem_q;
	logic [CNT_W-1:0]                skip_q;
	logic                            tail_q;
	logic [LEN_W-1:0]                pos_q;
	logic [LEN_W-1:0]                line_len_q;
	logic                            out_vld_q;
	logic [nuc2b_pkg::CHAR_W-1:0]    out_char_q;
	logic                            out_last_q;

	logic                            accept;
	logic                            step;
	logic [CW-1:0]                   count_ext;
	logic                            full_word;
	logic [SR_W+nuc2b_pkg::WORD_W-1:0] word_ext;
	logic [LEN_W-1:0]                limit;
	logic [LEN_W-1:0]                pos_inc;
	logic                            wrap;

	assign item.ready   = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign accept       = item.valid && (state_q == ST_IDLE);
	assign step         = ((state_q == ST_SYM) || (state_q == ST_NL)) &&
	                      (!out_vld_q || result.ready);

	assign count_ext    = {1'b0, item.data.symbol_count};
	assign full_word    = (count_ext >= CW'(SYMBOLS_PER_WORD));
	assign word_ext     = {{SR_W{1'b0}}, item.data.packed_word};

	assign limit        = (line_len_q < LEN_W'(SYMBOLS_PER_WORD)) ?
	                      LEN_W'(SYMBOLS_PER_WORD) : line_len_q;
	assign pos_inc      = pos_q + LEN_W'(1);
	// Newlines inside the text only come from full words.
	assign wrap         = !tail_q && (pos_inc >= limit);

	assign result.valid             = out_vld_q;
	assign result.data.out_char     = out_char_q;
	assign result.data.last_of_word = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= nuc2b_pkg::LINE_LENGTH_RESET;
		end else if (cfg.valid) begin
			line_len_q <= cfg.data.line_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rem_q     <= '0;
			skip_q    <= '0;
			tail_q    <= 1'b0;
			pos_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (step) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tail_q <= !full_word;
						if (full_word) begin
							rem_q   <= CNT_W'(SYMBOLS_PER_WORD);
							state_q <= ST_SYM;
						end else begin
							rem_q   <= CNT_W'(count_ext);
							skip_q  <= CNT_W'(SYMBOLS_PER_WORD) - CNT_W'(count_ext);
							state_q <= ST_SKIP;
						end
					end
				end
				ST_SKIP: begin
					// Discard the unused high pairs of a right-justified tail.
					skip_q <= skip_q - CNT_W'(1);
					if (skip_q == CNT_W'(1)) begin
						state_q <= (rem_q == '0) ? ST_NL : ST_SYM;
					end
				end
				ST_SYM: begin
					if (step) begin
						rem_q <= rem_q - CNT_W'(1);
						if (tail_q) begin
							if (rem_q == CNT_W'(1)) begin
								state_q <= ST_NL;
							end
						end else if (wrap) begin
							pos_q   <= '0;
							state_q <= ST_NL;
						end else begin
							pos_q <= pos_inc;
							if (rem_q == CNT_W'(1)) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_NL: begin
					if (step) begin
						if (tail_q) begin
							pos_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= (rem_q == '0) ? ST_IDLE : ST_SYM;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Shift register and output payload carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			sr_q <= word_ext[SR_W-1:0];
		end else if ((state_q == ST_SKIP) || ((state_q == ST_SYM) && step)) begin
			sr_q <= {sr_q[SR_W-3:0], 2'b00};
		end

		if (step) begin
			if (state_q == ST_SYM) begin
				out_char_q <= nuc2b_pkg::letter_of_code(sr_q[SR_W-1 -: 2]);
				out_last_q <= !tail_q && !wrap && (rem_q == CNT_W'(1));
			end else begin
				out_char_q <= nuc2b_pkg::NEWLINE_CHAR;
				out_last_q <= tail_q || (rem_q == '0);
			end
		end
	end

`ifndef SYNTHESIS
	a_sym_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SYM) |-> (rem_q != '0))
		else $error("symbol state entered with no symbols left");

	a_skip_only_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP) |-> tail_q)
		else $error("pair skipping on a full word");

	a_last_ends_word: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (state_q == ST_NL) && tail_q)
		|=> (state_q == ST_IDLE) && result.data.last_of_word)
		else $error("tail newline did not close the word");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted word produced no work");

	a_tail_resets_line: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_NL) && step && tail_q) |=> (pos_q == '0))
		else $error("line position not cleared after tail word");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for nucleotide_two_bit_unpacker_core: drives packed words and line lengths,
// predicts every output character with a small ledger class and checks each result transfer.
// Depends on nuc2b_pkg and nuc2b_stream_if from the source folder.
module testbench ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W  = nuc2b_pkg::WORD_W;
	localparam int COUNT_W = nuc2b_pkg::COUNT_W;
	localparam int CHAR_W  = nuc2b_pkg::CHAR_W;
	localparam int LEN_W   = nuc2b_pkg::LEN_W;

	localparam int SYMS        = 16;
	localparam int IDLE_LIMIT  = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 24;
	localparam int PHASE_WORDS = 46;
	localparam int NUM_PHASES  = 9;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SYMS);

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_T = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_C = 2'd3;

	class char_ledger;
		nuc2b_pkg::result_t due_chars[$];
		logic [LEN_W-1:0] line_len;
		logic [LEN_W-1:0] line_pos;
		int              words_seen;
		int              chars_checked;
		int              failures;

		function new();
			line_len = nuc2b_pkg::LINE_LENGTH_RESET;
			line_pos = '0;
			words_seen = 0;
			chars_checked = 0;
			failures = 0;
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function logic [CHAR_W-1:0] code_to_char(logic [1:0] code);
			case (code)
				CODE_A: return "a";
				CODE_T: return "t";
				CODE_G: return "g";
				default: return "c";
			endcase
		endfunction

		function void set_length(logic [LEN_W-1:0] len);
			line_len = len;
		endfunction

		// Works out every character one accepted word produces and queues them in order.
		function void note_word(nuc2b_pkg::item_t w);
			logic [CHAR_W-1:0]  chars[$];
			logic [LEN_W-1:0]   lim;
			int                 cnt;
			nuc2b_pkg::result_t r;
			lim = (line_len < SYMS) ? LEN_W'(SYMS) : line_len;
			cnt = w.symbol_count;
			words_seen++;
			if (cnt >= SYMS) begin
				for (int k = 0; k < SYMS; k++) begin
					chars.push_back(code_to_char(w.packed_word[2*(SYMS-1-k) +: 2]));
					line_pos = line_pos + 1'b1;
					if (line_pos >= lim) begin
						chars.push_back(nuc2b_pkg::NEWLINE_CHAR);
						line_pos = '0;
					end
				end
			end else begin
				// A tail word is right-justified, so only its low pairs carry symbols.
				for (int k = 0; k < cnt; k++) begin
					chars.push_back(code_to_char(w.packed_word[2*(cnt-1-k) +: 2]));
				end
				chars.push_back(nuc2b_pkg::NEWLINE_CHAR);
				line_pos = '0;
			end
			foreach (chars[i]) begin
				r.out_char = chars[i];
				r.last_of_word = (i == chars.size() - 1);
				due_chars.push_back(r);
			end
		endfunction

		function void check_char(nuc2b_pkg::result_t got);
			nuc2b_pkg::result_t want;
			chars_checked++;
			if (due_chars.size() == 0) begin
				flag($sformatf("unexpected character %02h last %0b", got.out_char,
					got.last_of_word));
			end else begin
				want = due_chars.pop_front();
				if (got.out_char !== want.out_char || got.last_of_word !== want.last_of_word) begin
					flag($sformatf("character %0d: expected %02h last %0b, got %02h last %0b",
						chars_checked, want.out_char, want.last_of_word,
						got.out_char, got.last_of_word));
				end
			end
		endfunction

		function void finish_check();
			if (due_chars.size() != 0) begin
				flag($sformatf("%0d expected characters never arrived", due_chars.size()));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	nuc2b_stream_if #(.payload_t(nuc2b_pkg::item_t))   item_ch ();
	nuc2b_stream_if #(.payload_t(nuc2b_pkg::result_t)) result_ch ();
	nuc2b_stream_if #(.payload_t(nuc2b_pkg::cfg_t))    cfg_ch ();

	nucleotide_two_bit_unpacker_core #(.SYMBOLS_PER_WORD(SYMS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	char_ledger ledger = new();

	bit quiet;
	bit long_hold_req;
	bit moved;
	int idle_cycles;
	int settings_used;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		quiet = 1'b0;
		long_hold_req = 1'b0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		int hold;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (hold == 0 && !quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 19);
			end
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Every transfer is observed here, inputs first so a prediction is always queued in time.
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (item_ch.valid && item_ch.ready) begin
				ledger.note_word(item_ch.data);
				moved = 1'b1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				ledger.set_length(cfg_ch.data.line_length);
				moved = 1'b1;
			end
			if (result_ch.valid && result_ch.ready) begin
				ledger.check_char(result_ch.data);
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic send_word(input logic [WORD_W-1:0] word, input logic [COUNT_W-1:0] count);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= '{packed_word: word, symbol_count: count};
		@(posedge clk);
		while (!(item_ch.valid && item_ch.ready)) @(posedge clk);
	endtask

	// One file: a run of full words, usually closed by a tail word.
	task automatic send_file(inout int sent);
		int n_full;
		int pick;
		n_full = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
		for (int i = 0; i < n_full; i++) begin
			send_word($urandom, ($urandom_range(0, 7) == 0) ?
				COUNT_W'($urandom_range(17, 31)) : FULL_COUNT);
			sent++;
		end
		pick = $urandom_range(0, 9);
		if (pick < 8) begin
			send_word($urandom, COUNT_W'($urandom_range(1, SYMS - 1)));
			sent++;
		end else if (pick == 8) begin
			send_word($urandom, '0);
			sent++;
		end
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (ledger.due_chars.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_length(input logic [LEN_W-1:0] len);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= '{line_length: len};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [LEN_W-1:0] lengths[NUM_PHASES];
		int sent;
		settings_used = 1;
		lengths = '{8'd255, 8'd16, 8'd0, 8'd1, 8'd15, 8'd17, 8'd200, 8'd60, 8'd60};
		lengths[7] = LEN_W'($urandom_range(1, 255));
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed: uniform and mixed words under the reset line length, so the fourth
		// full word crosses the sixtieth character, then every tail size and odd counts.
		send_word(32'h0000_0000, FULL_COUNT);
		send_word(32'hFFFF_FFFF, FULL_COUNT);
		send_word(32'h1B1B_1B1B, FULL_COUNT);
		send_word(32'hE4E4_E4E4, FULL_COUNT);
		send_word(32'h5555_5555, FULL_COUNT);
		send_word(32'hAAAA_AAAA, 5'd31);
		send_word(32'hFFFF_FFFE, 5'd1);
		send_word($urandom, 5'd0);
		send_word($urandom, 5'd17);
		for (int c = 1; c < SYMS; c++) begin
			send_word($urandom, COUNT_W'(c));
		end

		// Each phase ends on full words so the next length can find a line in progress.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			write_length(lengths[ph]);
			quiet = (ph == NUM_PHASES - 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
			if (ph == 2) begin
				long_hold_req = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_WORDS) send_file(sent);
			repeat (4) send_word($urandom, FULL_COUNT);
		end

		wait_idle();
		repeat (40) @(posedge clk);
		ledger.finish_check();
		$display("checked %0d characters from %0d words over %0d line-length settings,",
			ledger.chars_checked, ledger.words_seen, settings_used);
		$display("with random stalls on both sides and one long output hold-off");
		if (ledger.failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d failures", ledger.failures);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
